/* rtl/core/hrlp_pkg.sv */
// Shared types and constants for the HTTP request-line parser.
`timescale 1ns / 1ps

package hrlp_pkg;

  // Default width of the byte offset counter
  localparam int OFFSET_BITS_DEF = 16;
  // Width of the offset fields on the result channel
  localparam int OUT_OFS_W = 16;

  // Characters of interest
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_SP   = 8'h20;
  localparam logic [7:0] ASCII_MAX = 8'd127;

  // Method words, first character in the most significant byte
  localparam logic [23:0] WORD_GET    = "GET";
  localparam logic [31:0] WORD_POST   = "POST";
  localparam logic [23:0] WORD_PUT    = "PUT";
  localparam logic [47:0] WORD_DELETE = "DELETE";

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_INCOMPLETE = 2'd1,
    ST_BAD        = 2'd2,
    ST_TOO_LONG   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    METH_GET    = 2'd0,
    METH_POST   = 2'd1,
    METH_PUT    = 2'd2,
    METH_DELETE = 2'd3
  } method_t;

  // One byte beat handed from the input register to the parser
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } beat_t;

  // One parse result
  typedef struct packed {
    status_t              status;
    method_t              method_code;
    logic [OUT_OFS_W-1:0] url_start;
    logic [OUT_OFS_W-1:0] url_length;
    logic [OUT_OFS_W-1:0] body_offset;
  } result_t;

endpackage

/* rtl/core/http_request_line_parser_core.sv */
// Top level of the HTTP request-line parser: input stage, parser, result register.
`timescale 1ns / 1ps

// Usage:
// The input channel (in_valid/in_ready) carries one buffer byte per beat, with
// in_last set on the final byte of a request buffer. The result channel
// (out_valid/out_ready) gives at most one beat per buffer: the verdict when
// CR LF CR LF completes, or incomplete/too long at the last byte. Bytes after
// a result are consumed silently; parser state clears after every last byte.
// Throughput: one byte per cycle while the result slot is free, set by the
// combinational parse step between the input register and the result register.
// Bytes pass the input register, then the parse step into the result register.
// When the receiver stalls with a result held, the input register still takes
// one more byte and then in_ready drops until out_ready frees the result slot.
// Reset (rst_n low, synchronous) empties both registers and clears the parser.

module http_request_line_parser_core
  import hrlp_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [1:0]           out_method_code,
  output logic [OUT_OFS_W-1:0] out_url_start,
  output logic [OUT_OFS_W-1:0] out_url_length,
  output logic [OUT_OFS_W-1:0] out_body_offset
);

  beat_t   beat;
  logic    out_free;
  logic    res_valid;
  result_t res;
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;

  // The result slot is free when empty or being drained
  assign out_free = !out_valid_r || out_ready;

  hrlp_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last      (in_last),
    .take         (out_free),
    .beat         (beat)
  );

  hrlp_parse #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat      (beat),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_res_r.status;
  assign out_method_code = out_res_r.method_code;
  assign out_url_start   = out_res_r.url_start;
  assign out_url_length  = out_res_r.url_length;
  assign out_body_offset = out_res_r.body_offset;

endmodule

/* rtl/core/hrlp_in_reg.sv */
// Input register stage: holds one byte beat until the parser takes it.
`timescale 1ns / 1ps

module hrlp_in_reg
  import hrlp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last,
  input  logic       take,
  output beat_t      beat
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       last_r;
  logic       accept;

  // Free when empty or when the held beat leaves this cycle
  assign in_ready = !valid_r || take;
  assign accept   = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= in_data_byte;
      last_r <= in_last;
    end
  end

  assign beat.valid = valid_r && take;
  assign beat.data  = data_r;
  assign beat.last  = last_r;

endmodule

/* rtl/core/hrlp_parse.sv */
// Parser state and decision logic: offset, terminator match, spaces, method.
`timescale 1ns / 1ps

module hrlp_parse
  import hrlp_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  beat_t   beat,
  output logic    res_valid,
  output result_t res
);

  localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};
  localparam logic [OFFSET_BITS-1:0] ONE     = OFFSET_BITS'(1);
  localparam int                     NKEEP   = 7;
  // Terminator match progress: bytes of CR LF CR LF seen so far
  localparam logic [1:0] TM_NONE  = 2'd0;
  localparam logic [1:0] TM_CR    = 2'd1;
  localparam logic [1:0] TM_CRLF  = 2'd2;
  localparam logic [1:0] TM_CRLFC = 2'd3;

  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [1:0]             term_r, term_nxt;
  logic                   non_ascii_r, non_ascii_nxt;
  logic [7:0]             mchar_r [NKEEP];
  logic [OFFSET_BITS-1:0] fs_off_r, fs_off_nxt;
  logic                   fs_found_r, fs_found_nxt;
  logic [OFFSET_BITS-1:0] ss_off_r, ss_off_nxt;
  logic                   ss_found_r, ss_found_nxt;
  logic                   line_end_r, line_end_nxt;
  logic                   given_r, given_nxt;

  logic                   active;
  logic                   is_cr, is_lf, is_sp;
  logic                   sat, done;
  logic                   keep_wr;
  logic                   hit_get, hit_post, hit_put, hit_delete, hit_any;
  method_t                meth;
  status_t                status;
  logic [OFFSET_BITS:0]   us_w;
  logic [OFFSET_BITS:0]   bo_w;
  logic [OFFSET_BITS-1:0] ul_w;

  assign active  = beat.valid && !given_r;
  assign is_cr   = beat.data == CHAR_CR;
  assign is_lf   = beat.data == CHAR_LF;
  assign is_sp   = beat.data == CHAR_SP;
  assign sat     = pos_r == POS_MAX;
  assign done    = is_lf && (term_r == TM_CRLFC);
  assign keep_wr = active && (pos_r < OFFSET_BITS'(NKEEP));

  // Next state for one accepted beat
  always_comb begin
    pos_nxt       = pos_r;
    term_nxt      = term_r;
    non_ascii_nxt = non_ascii_r;
    fs_off_nxt    = fs_off_r;
    fs_found_nxt  = fs_found_r;
    ss_off_nxt    = ss_off_r;
    ss_found_nxt  = ss_found_r;
    line_end_nxt  = line_end_r;
    given_nxt     = given_r;
    if (active) begin
      if (beat.data > ASCII_MAX) begin
        non_ascii_nxt = 1'b1;
      end
      // Spaces count only inside the request line
      if (!line_end_r) begin
        if (is_lf && (term_r == TM_CR)) begin
          line_end_nxt = 1'b1;
        end else if (is_sp) begin
          if (!fs_found_r) begin
            fs_found_nxt = 1'b1;
            fs_off_nxt   = pos_r;
          end else if (!ss_found_r) begin
            ss_found_nxt = 1'b1;
            ss_off_nxt   = pos_r;
          end
        end
      end
      // Terminator match; a stray CR restarts at one byte
      if (is_cr) begin
        term_nxt = (term_r == TM_CRLF) ? TM_CRLFC : TM_CR;
      end else if (is_lf && (term_r == TM_CR)) begin
        term_nxt = TM_CRLF;
      end else begin
        term_nxt = TM_NONE;
      end
      if (done || beat.last) begin
        given_nxt = 1'b1;
      end
      if (!sat) begin
        pos_nxt = pos_r + ONE;
      end
    end
  end

  // Control state; the buffer end clears everything
  always_ff @(posedge clk) begin
    if (!rst_n || (beat.valid && beat.last)) begin
      pos_r       <= '0;
      term_r      <= TM_NONE;
      non_ascii_r <= 1'b0;
      fs_off_r    <= '0;
      fs_found_r  <= 1'b0;
      ss_off_r    <= '0;
      ss_found_r  <= 1'b0;
      line_end_r  <= 1'b0;
      given_r     <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      term_r      <= term_nxt;
      non_ascii_r <= non_ascii_nxt;
      fs_off_r    <= fs_off_nxt;
      fs_found_r  <= fs_found_nxt;
      ss_off_r    <= ss_off_nxt;
      ss_found_r  <= ss_found_nxt;
      line_end_r  <= line_end_nxt;
      given_r     <= given_nxt;
    end
  end

  // First seven bytes of the buffer, one register each
  always_ff @(posedge clk) begin
    if (!rst_n || (beat.valid && beat.last)) begin
      for (int i = 0; i < NKEEP; i++) begin
        mchar_r[i] <= '0;
      end
    end else if (keep_wr) begin
      mchar_r[pos_r[2:0]] <= beat.data;
    end
  end

  // Method word match against the bytes ahead of the first space
  assign hit_get = (fs_off_r == OFFSET_BITS'(3)) &&
                   ({mchar_r[0], mchar_r[1], mchar_r[2]} == WORD_GET);
  assign hit_post = (fs_off_r == OFFSET_BITS'(4)) &&
                    ({mchar_r[0], mchar_r[1], mchar_r[2], mchar_r[3]} == WORD_POST);
  assign hit_put = (fs_off_r == OFFSET_BITS'(3)) &&
                   ({mchar_r[0], mchar_r[1], mchar_r[2]} == WORD_PUT);
  assign hit_delete = (fs_off_r == OFFSET_BITS'(6)) &&
                      ({mchar_r[0], mchar_r[1], mchar_r[2],
                        mchar_r[3], mchar_r[4], mchar_r[5]} == WORD_DELETE);
  assign hit_any = hit_get || hit_post || hit_put || hit_delete;

  always_comb begin
    if (hit_get) begin
      meth = METH_GET;
    end else if (hit_post) begin
      meth = METH_POST;
    end else if (hit_put) begin
      meth = METH_PUT;
    end else begin
      meth = METH_DELETE;
    end
  end

  // Verdict, in order of precedence
  always_comb begin
    if (sat) begin
      status = ST_TOO_LONG;
    end else if (!done) begin
      status = ST_INCOMPLETE;
    end else if (non_ascii_r || !fs_found_r || !hit_any) begin
      status = ST_BAD;
    end else if (!ss_found_r) begin
      status = ST_INCOMPLETE;
    end else begin
      status = ST_OK;
    end
  end

  // Offsets; the body starts right after the final LF
  assign us_w = {1'b0, fs_off_r} + {1'b0, ONE};
  assign bo_w = {1'b0, pos_r} + {1'b0, ONE};
  assign ul_w = ss_off_r - fs_off_r - ONE;

  assign res_valid = active && (done || beat.last);

  always_comb begin
    res.status      = status;
    res.method_code = METH_GET;
    res.url_start   = '0;
    res.url_length  = '0;
    res.body_offset = '0;
    if (status == ST_OK) begin
      res.method_code = meth;
      res.url_start   = OUT_OFS_W'(us_w);
      res.url_length  = OUT_OFS_W'(ul_w);
      res.body_offset = OUT_OFS_W'(bo_w);
    end
  end

`ifndef SYNTH
  // The end of the buffer leaves the parser cleared
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    beat.valid && beat.last |=> (pos_r == '0) && !given_r && (term_r == TM_NONE))
    else $error("parser state not cleared after last byte");

  // Once a result is out, nothing more until the buffer ends
  a_given_holds: assert property (@(posedge clk) disable iff (!rst_n)
    beat.valid && given_r && !beat.last |=> given_r)
    else $error("result flag dropped before end of buffer");

  // An ok verdict only comes on the LF that closes the blank line
  a_ok_on_term: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && (res.status == ST_OK) |-> is_lf && (term_r == TM_CRLFC) && ss_found_r)
    else $error("ok result without terminator");

  // Non-ok results carry zero fields
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && (res.status != ST_OK) |->
      (res.url_start == '0) && (res.url_length == '0) && (res.body_offset == '0))
    else $error("failed result carries offsets");
`endif

endmodule
